// ===== rtl/mtc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtc_pkg
// Types, tables and constants shared by the marching tetrahedra cube unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

   localparam int unsigned COORD_W  = 8;
   localparam int unsigned DENS_W   = 16;
   localparam int unsigned FRAC_W   = 17;
   localparam int unsigned POS_W    = 25;
   localparam int unsigned TET_W    = 3;
   localparam int unsigned NUM_TET  = 6;
   localparam logic [DENS_W-1:0] THRESH_RESET = 16'd22938;
   localparam logic [TET_W-1:0]  TET_LAST_IDX = 3'd5;
   localparam logic [2:0]        EDGE_LAST    = 3'd5;

   // one queued cube: lower corner, densities, inside bits and tet summary
   typedef struct packed {
      logic [2:0][COORD_W-1:0] base;
      logic [7:0][DENS_W-1:0]  dens;
      logic [7:0]              in_mask;
      logic [5:0]              active;
      logic [TET_W-1:0]        last_tet;
   } mtc_cube_type;

   typedef struct packed {
      logic empty;
      logic full;
   } mtc_qstat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_DIV,
      ST_POINT,
      ST_EMIT1,
      ST_EMIT2
   } mtc_state_type;

   // corner k of tetrahedron t, all sharing the diagonal from corner 0 to 6
   function automatic logic [2:0] tet_corner(input logic [2:0] t, input logic [1:0] k);
      logic [11:0] row;
      case (t)
         3'd0:    row = {3'd6, 3'd2, 3'd1, 3'd0};
         3'd1:    row = {3'd6, 3'd3, 3'd2, 3'd0};
         3'd2:    row = {3'd6, 3'd7, 3'd3, 3'd0};
         3'd3:    row = {3'd6, 3'd4, 3'd7, 3'd0};
         3'd4:    row = {3'd6, 3'd5, 3'd4, 3'd0};
         3'd5:    row = {3'd6, 3'd1, 3'd5, 3'd0};
         default: row = '0;
      endcase
      return row[k*3 +: 3];
   endfunction

   // end points of tetrahedron edge e, as local corner slots
   function automatic logic [1:0] edge_a(input logic [2:0] e);
      case (e)
         3'd0, 3'd1, 3'd2: return 2'd0;
         3'd3, 3'd4:       return 2'd1;
         default:          return 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] edge_b(input logic [2:0] e);
      case (e)
         3'd0:       return 2'd1;
         3'd1, 3'd3: return 2'd2;
         default:    return 2'd3;
      endcase
   endfunction

   // corner offset, bit 0 first axis, bit 1 second, bit 2 third
   function automatic logic [2:0] corner_off(input logic [2:0] c);
      case (c)
         3'd0:    return 3'b000;
         3'd1:    return 3'b001;
         3'd2:    return 3'b011;
         3'd3:    return 3'b010;
         3'd4:    return 3'b100;
         3'd5:    return 3'b101;
         3'd6:    return 3'b111;
         default: return 3'b110;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mtc_front.sv =====
// ----------------------------------------------------------------------------
// mtc_front
// Holds the threshold, accepts cubes, classifies corners and tetrahedra, and
// queues only cubes that produce triangles.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_front
   import mtc_pkg::*;
#(
   parameter int GRID_SIZE = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COORD_W-1:0]  req_cube_x,
   input  wire logic [COORD_W-1:0]  req_cube_y,
   input  wire logic [COORD_W-1:0]  req_cube_z,
   input  wire logic [7:0][DENS_W-1:0] req_dens,
   input  wire logic                csr_write_en,
   input  wire logic [DENS_W-1:0]   csr_write_data,
   input  wire mtc_qstat_type       qstat,
   output logic                     push,
   output mtc_cube_type             push_data,
   output logic [DENS_W-1:0]        threshold
);

   localparam logic [10:0] GRID_LIM = 11'(GRID_SIZE);

   logic [DENS_W-1:0] thr_ff, thr_in;
   logic [7:0]        in_mask;
   logic [5:0]        active;
   logic [TET_W-1:0]  last_tet;
   logic              out_grid;

   // threshold register
   always_comb begin
      thr_in = csr_write_en ? csr_write_data : thr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign threshold = thr_ff;

   // classify corners and tetrahedra
   always_comb begin
      logic [3:0] ins;
      for (int c = 0; c < 8; c++) begin
         in_mask[c] = req_dens[c] > thr_ff;
      end
      for (int t = 0; t < NUM_TET; t++) begin
         for (int k = 0; k < 4; k++) begin
            ins[k] = in_mask[tet_corner(3'(t), 2'(k))];
         end
         active[t] = (ins != 4'b0000) && (ins != 4'b1111);
      end
      last_tet = '0;
      for (int t = 0; t < NUM_TET; t++) begin
         if (active[t]) begin
            last_tet = TET_W'(t);
         end
      end
      out_grid = ({3'b0, req_cube_x} >= GRID_LIM) || ({3'b0, req_cube_y} >= GRID_LIM) ||
                 ({3'b0, req_cube_z} >= GRID_LIM);
   end

   // accept while the queue has room; drop cubes with nothing to emit
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full && !out_grid && (active != 6'b0);

   always_comb begin
      push_data.base     = {req_cube_z, req_cube_y, req_cube_x};
      push_data.dens     = req_dens;
      push_data.in_mask  = in_mask;
      push_data.active   = active;
      push_data.last_tet = last_tet;
   end

endmodule

`default_nettype wire

// ===== rtl/mtc_queue.sv =====
// ----------------------------------------------------------------------------
// mtc_queue
// Four-entry cube queue between the classifier and the triangle sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_queue
   import mtc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire mtc_cube_type  push_data,
   input  wire logic          pop,
   output mtc_cube_type       head,
   output mtc_qstat_type      qstat
);

   mtc_cube_type mem_ff [4];
   logic [1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]   cnt_ff, cnt_in;

   // advance pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head        = mem_ff[rd_ff];
   assign qstat.empty = (cnt_ff == 3'd0);
   assign qstat.full  = (cnt_ff == 3'd4);

endmodule

`default_nettype wire

// ===== rtl/mtc_back.sv =====
// ----------------------------------------------------------------------------
// mtc_back
// Walks the tetrahedra of one queued cube, interpolates crossing edges with a
// bit-serial divider and sends triangles through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_back
   import mtc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mtc_cube_type       head,
   input  wire mtc_qstat_type      qstat,
   output logic                    pop,
   input  wire logic [DENS_W-1:0]  threshold,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0][2:0][POS_W-1:0] rsp_pts,
   output logic [TET_W-1:0]        rsp_tet_index,
   output logic                    rsp_last_of_cube
);

   mtc_state_type state_ff, state_in;
   mtc_cube_type  cube_ff, cube_in;
   logic [TET_W-1:0] tet_ff, tet_in;
   logic [2:0]    edge_ff, edge_in, n_ff, n_in;
   logic [2:0]    ca_ff, ca_in, cb_ff, cb_in;
   logic [3:0][2:0][POS_W-1:0] pts_ff, pts_in;
   logic [FRAC_W-1:0] rem_ff, rem_in, q_ff, q_in;
   logic [DENS_W-1:0] den_ff, den_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          val_ff, val_in;
   logic [2:0][2:0][POS_W-1:0] opts_ff, opts_in;
   logic [TET_W-1:0] otet_ff, otet_in;
   logic          olast_ff, olast_in;

   logic          out_free;
   logic          tet_done;

   assign out_free = !val_ff || !rsp_stall;
   assign tet_done = (tet_ff == cube_ff.last_tet);

   // sequencer: next state, divider steps and triangle loads
   always_comb begin
      logic [2:0]        ca, cb;
      logic              ina, inb;
      logic [DENS_W-1:0] da, db, num, den;
      logic [FRAC_W:0]   trial;
      logic [POS_W-1:0]  p;
      logic [2:0]        oa, ob;

      state_in = state_ff;
      cube_in  = cube_ff;
      tet_in   = tet_ff;
      edge_in  = edge_ff;
      n_in     = n_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      pts_in   = pts_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff && rsp_stall;
      opts_in  = opts_ff;
      otet_in  = otet_ff;
      olast_in = olast_ff;
      pop      = 1'b0;

      ca    = tet_corner(tet_ff, edge_a(edge_ff));
      cb    = tet_corner(tet_ff, edge_b(edge_ff));
      ina   = cube_ff.in_mask[ca];
      inb   = cube_ff.in_mask[cb];
      da    = cube_ff.dens[ca];
      db    = cube_ff.dens[cb];
      num   = ina ? da - threshold : threshold - da;
      den   = ina ? da - db : db - da;
      trial = {rem_ff, 1'b0};
      oa    = corner_off(ca_ff);
      ob    = corner_off(cb_ff);
      p     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               cube_in  = head;
               tet_in   = '0;
               edge_in  = '0;
               n_in     = '0;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            if (!cube_ff.active[tet_ff]) begin
               // skip a tetrahedron without crossings
               tet_in  = tet_ff + 3'd1;
               edge_in = '0;
               n_in    = '0;
            end else if (ina != inb) begin
               // start the divide; a full ratio is settled here
               ca_in    = ca;
               cb_in    = cb;
               den_in   = den;
               rem_in   = (num == den) ? '0 : {1'b0, num};
               q_in     = {16'b0, num == den};
               cnt_in   = 4'd15;
               state_in = ST_DIV;
            end else if (edge_ff == EDGE_LAST) begin
               state_in = ST_EMIT1;
            end else begin
               edge_in = edge_ff + 3'd1;
            end
         end
         ST_DIV: begin
            if (trial >= {2'b0, den_ff}) begin
               rem_in = FRAC_W'(trial - {2'b0, den_ff});
               q_in   = {q_ff[FRAC_W-2:0], 1'b1};
            end else begin
               rem_in = trial[FRAC_W-1:0];
               q_in   = {q_ff[FRAC_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            for (int ax = 0; ax < 3; ax++) begin
               p = {({1'b0, cube_ff.base[ax]} + {8'b0, oa[ax]}), 16'b0};
               if (ob[ax] && !oa[ax]) begin
                  p = p + {8'b0, q_ff};
               end else if (!ob[ax] && oa[ax]) begin
                  p = p - {8'b0, q_ff};
               end
               pts_in[n_ff[1:0]][ax] = p;
            end
            n_in = n_ff + 3'd1;
            if (edge_ff == EDGE_LAST) begin
               state_in = ST_EMIT1;
            end else begin
               edge_in  = edge_ff + 3'd1;
               state_in = ST_EDGE;
            end
         end
         ST_EMIT1: begin
            if (out_free) begin
               val_in   = 1'b1;
               opts_in  = {pts_ff[2], pts_ff[1], pts_ff[0]};
               otet_in  = tet_ff;
               olast_in = (n_ff == 3'd3) && tet_done;
               if (n_ff == 3'd4) begin
                  state_in = ST_EMIT2;
               end else if (tet_done) begin
                  state_in = ST_IDLE;
               end else begin
                  tet_in   = tet_ff + 3'd1;
                  edge_in  = '0;
                  n_in     = '0;
                  state_in = ST_EDGE;
               end
            end
         end
         ST_EMIT2: begin
            if (out_free) begin
               val_in   = 1'b1;
               opts_in  = {pts_ff[3], pts_ff[2], pts_ff[0]};
               otet_in  = tet_ff;
               olast_in = tet_done;
               if (tet_done) begin
                  state_in = ST_IDLE;
               end else begin
                  tet_in   = tet_ff + 3'd1;
                  edge_in  = '0;
                  n_in     = '0;
                  state_in = ST_EDGE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         val_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         val_ff   <= val_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cube_ff  <= cube_in;
      tet_ff   <= tet_in;
      edge_ff  <= edge_in;
      n_ff     <= n_in;
      ca_ff    <= ca_in;
      cb_ff    <= cb_in;
      pts_ff   <= pts_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      den_ff   <= den_in;
      cnt_ff   <= cnt_in;
      opts_ff  <= opts_in;
      otet_ff  <= otet_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid        = val_ff;
   assign rsp_pts          = opts_ff;
   assign rsp_tet_index    = otet_ff;
   assign rsp_last_of_cube = olast_ff;

endmodule

`default_nettype wire

// ===== rtl/marching_tetrahedra_cube_top.sv =====
// ----------------------------------------------------------------------------
// marching_tetrahedra_cube_top
// Marching tetrahedra cube unit: one grid cube in, up to twelve triangles out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one cube (lower corner index and eight Q0.16 densities);
//   a transfer happens when req_valid is high and req_stall is low.
//   rsp_* carries one triangle per transfer, with the tetrahedron index and a
//   flag on the final triangle of the cube. Cubes with no surface crossing,
//   or outside the grid, produce no triangles.
//   csr_write_en / csr_write_data load the threshold; write only when idle.
// Flow: a cube without crossings is dropped by the classifier.
//   A cube with crossings waits in a four-entry queue; the sequencer takes it,
//   steps past each edge without a crossing and each tetrahedron skipped,
//   runs setup, 16 divide steps and the point for each crossing, and then
//   emits each triangle.
// Reset: synchronous; threshold returns to 22938, queue and output empty.
// Stall: a stalled triangle holds in the output register; the sequencer
//   waits, and the queue fills before req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_tetrahedra_cube_top
   import mtc_pkg::*;
#(
   parameter int GRID_SIZE = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [COORD_W-1:0] req_cube_x,
   input  wire logic [COORD_W-1:0] req_cube_y,
   input  wire logic [COORD_W-1:0] req_cube_z,
   input  wire logic [DENS_W-1:0]  req_dens_000,
   input  wire logic [DENS_W-1:0]  req_dens_100,
   input  wire logic [DENS_W-1:0]  req_dens_110,
   input  wire logic [DENS_W-1:0]  req_dens_010,
   input  wire logic [DENS_W-1:0]  req_dens_001,
   input  wire logic [DENS_W-1:0]  req_dens_101,
   input  wire logic [DENS_W-1:0]  req_dens_111,
   input  wire logic [DENS_W-1:0]  req_dens_011,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [POS_W-1:0]        rsp_p0_x,
   output logic [POS_W-1:0]        rsp_p0_y,
   output logic [POS_W-1:0]        rsp_p0_z,
   output logic [POS_W-1:0]        rsp_p1_x,
   output logic [POS_W-1:0]        rsp_p1_y,
   output logic [POS_W-1:0]        rsp_p1_z,
   output logic [POS_W-1:0]        rsp_p2_x,
   output logic [POS_W-1:0]        rsp_p2_y,
   output logic [POS_W-1:0]        rsp_p2_z,
   output logic [TET_W-1:0]        rsp_tet_index,
   output logic                    rsp_last_of_cube,
   input  wire logic               csr_write_en,
   input  wire logic [DENS_W-1:0]  csr_write_data
);

   mtc_qstat_type qstat;
   mtc_cube_type  push_data, head;
   logic          push, pop;
   logic [DENS_W-1:0] threshold;
   logic [7:0][DENS_W-1:0] dens;
   logic [2:0][2:0][POS_W-1:0] pts;

   assign dens = {req_dens_011, req_dens_111, req_dens_101, req_dens_001,
                  req_dens_010, req_dens_110, req_dens_100, req_dens_000};

   mtc_front #(
      .GRID_SIZE(GRID_SIZE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cube_x     (req_cube_x),
      .req_cube_y     (req_cube_y),
      .req_cube_z     (req_cube_z),
      .req_dens       (dens),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .qstat          (qstat),
      .push           (push),
      .push_data      (push_data),
      .threshold      (threshold)
   );

   mtc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   mtc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .qstat            (qstat),
      .pop              (pop),
      .threshold        (threshold),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pts          (pts),
      .rsp_tet_index    (rsp_tet_index),
      .rsp_last_of_cube (rsp_last_of_cube)
   );

   assign rsp_p0_x = pts[0][0];
   assign rsp_p0_y = pts[0][1];
   assign rsp_p0_z = pts[0][2];
   assign rsp_p1_x = pts[1][0];
   assign rsp_p1_y = pts[1][1];
   assign rsp_p1_z = pts[1][2];
   assign rsp_p2_x = pts[2][0];
   assign rsp_p2_y = pts[2][1];
   assign rsp_p2_z = pts[2][2];

`ifndef ASSERT_OFF
   // a triangle always names one of the six tetrahedra
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tet_index <= TET_LAST_IDX))
      else $error("tetrahedron index out of range");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("triangle present after reset");

   // the queue never takes a cube while full
   assert property (@(posedge clock) disable iff (reset) !(push && qstat.full))
      else $error("cube queue overflow");
`endif

endmodule

`default_nettype wire
